@@ rtl/fixed_width_decimal_formatter_unit_assert.svh @@
// Assertion macros for the decimal formatter.
// FFMT_ASSERT_NOW checks the consequent in the same cycle,
// FFMT_ASSERT_NEXT checks it in the next cycle.
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define FFMT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decimal formatter assertion failed");
`define FFMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decimal formatter assertion failed");
`else
`define FFMT_ASSERT_NOW(label, ante, cons)
`define FFMT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/ffmt_pkg.sv @@
`default_nettype none

package ffmt_pkg;

	localparam int VAL_W      = 32;
	localparam int CNT_W      = 4;
	localparam int NUM_DIGITS = 10;
	localparam int STEP_W     = $clog2(VAL_W);
	localparam int IN_DATA_W  = ((VAL_W + CNT_W + 7) / 8) * 8;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(NUM_DIGITS);

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	// request into the conversion unit
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] mag;
	} conv_req_t;

	// status back from the conversion unit
	typedef struct packed {
		logic busy;
		logic done;
	} conv_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_SETUP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/ffmt_dabble.sv @@
`default_nettype none

// Shift-and-add-3 binary to BCD converter, one bit per cycle.
module ffmt_dabble (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffmt_pkg::conv_req_t req,
	output ffmt_pkg::conv_sts_t     sts,
	output ffmt_pkg::digits_t       digits
);
	import ffmt_pkg::*;

	logic [VAL_W-1:0]  mag_q;
	digits_t           bcd_q;
	digits_t           adj;
	digits_t           bcd_nxt;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	// correct each digit, then shift the whole register left by one bit
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_nxt[0] = {adj[0][2:0], mag_q[VAL_W-1]};
		for (int i = 1; i < NUM_DIGITS; i++) begin
			bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[VAL_W-2:0], 1'b0};
			bcd_q <= bcd_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign digits   = bcd_q;

endmodule

`default_nettype wire

@@ rtl/fixed_width_decimal_formatter_unit.sv @@
// Per number: load, 32 conversion steps in the shift-and-add-3 unit, done
// handoff, setup, then one character a cycle while the output is not stalled.
// Characters emitted per number: 1 to 11. A new number is taken only in idle,
// after the previous number's last character has been registered.
// Reset: arst_n clears the sequencer and the output valid asynchronously.
`default_nettype none

`include "fixed_width_decimal_formatter_unit_assert.svh"

module fixed_width_decimal_formatter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [ffmt_pkg::IN_DATA_W-1:0] s_tdata,  // value_bits, pad_digits, zero fill
	input  wire logic                           s_tuser,  // cmd
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,  // char_code
	output logic                                m_tlast
);
	import ffmt_pkg::*;

	state_t           state_q;
	logic             neg_q;
	logic             sgn_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ndig_q;
	logic [CNT_W-1:0] tlen_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] k_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	conv_req_t        conv_req;
	conv_sts_t        conv_sts;
	digits_t          digits;
	digits_t          trunc;
	logic             accept;
	logic [VAL_W-1:0] in_val;
	logic [CNT_W-1:0] in_pad;
	logic             in_neg;
	logic [CNT_W-1:0] ndig;
	logic             nonzero;
	logic             neg_eff;
	logic [CNT_W-1:0] tlen;
	logic [CNT_W-1:0] padw;
	logic [CNT_W-1:0] digidx;
	logic [7:0]       ch;
	logic             out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_val   = s_tdata[VAL_W-1:0];
	assign in_pad   = s_tdata[VAL_W +: CNT_W];
	assign in_neg   = s_tuser && in_val[VAL_W-1];

	// start conversion on the magnitude
	assign conv_req.start = accept;
	assign conv_req.mag   = in_neg ? (VAL_W'(0) - in_val) : in_val;

	ffmt_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.sts    (conv_sts),
		.digits (digits)
	);

	// drop digits at or above the digit count, find the leading digit
	always_comb begin
		ndig = CNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			trunc[i] = (CNT_W'(i) < count_q) ? digits[i] : 4'd0;
			if (trunc[i] != 4'd0) ndig = CNT_W'(i + 1);
		end
		nonzero = (trunc != '0);
		neg_eff = neg_q && nonzero;
		tlen    = ndig + CNT_W'(neg_eff);
		padw    = count_q + CNT_W'(sgn_q);
	end

	// pick the character at position k
	always_comb begin
		digidx = ndig_q - CNT_W'(1) - k_q + CNT_W'(neg_q);
		if (k_q >= tlen_q) begin
			ch = CH_SPACE;
		end else if (neg_q && (k_q == '0)) begin
			ch = CH_MINUS;
		end else if (digidx < CNT_W'(NUM_DIGITS)) begin
			ch = CH_ZERO + {4'd0, trunc[digidx]};
		end else begin
			ch = CH_ZERO;
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (conv_sts.done) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					k_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
						if (k_q == total_q - CNT_W'(1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold request fields and text layout
	always_ff @(posedge clk) begin
		if (accept) begin
			sgn_q   <= s_tuser;
			neg_q   <= in_neg;
			count_q <= (in_pad > MAX_COUNT) ? MAX_COUNT : in_pad;
		end
		if (state_q == ST_SETUP) begin
			neg_q   <= neg_eff;
			ndig_q  <= ndig;
			tlen_q  <= tlen;
			total_q <= (tlen > padw) ? tlen : padw;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_char_q <= ch;
			out_last_q <= (k_q == total_q - CNT_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	// checks
	`FFMT_ASSERT_NEXT(a_busy_after_req, accept, !s_tready)
	`FFMT_ASSERT_NOW(a_done_in_conv, conv_sts.done, state_q == ST_CONV)
	`FFMT_ASSERT_NOW(a_conv_busy_in_conv, conv_sts.busy, state_q == ST_CONV)
	`FFMT_ASSERT_NOW(a_legal_char, m_tvalid,
		(m_tdata == CH_SPACE) || (m_tdata == CH_MINUS) ||
		((m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE)))

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffmt_pkg::*;

	typedef struct {
		bit          is_signed;
		logic [31:0] value;
		logic [3:0]  digits;
	} number_req_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;  // value_bits, pad_digits, zero fill
	logic                 s_tuser = 1'b0; // cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // char_code
	logic                 m_tlast;

	number_req_t pending_numbers[$];
	text_char_t  char_expect[$];
	number_req_t presented;
	text_char_t  want;
	int          numbers_total = 0;
	int          numbers_taken = 0;
	int          errors = 0;
	int          cycles = 0;
	logic        calm;
	logic        req_fire;

	localparam int CYCLE_LIMIT = 400000;

	fixed_width_decimal_formatter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Build the padded decimal text of one number and queue its characters
	function automatic void predict_text(bit is_signed, logic [31:0] raw, logic [3:0] cnt_in);
		int unsigned cnt;
		bit          neg;
		logic [31:0] mag;
		logic [31:0] modulus;
		logic [7:0]  rev_digits[$];
		logic [7:0]  text[$];
		int          width;
		int          total;
		text_char_t  ch;
		cnt = (cnt_in > 4'd10) ? 10 : int'(cnt_in);
		neg = is_signed && raw[31];
		mag = neg ? (32'd0 - raw) : raw;
		// reduce modulo 10^cnt; magnitude reduction keeps truncation toward zero
		if (cnt < 10) begin
			modulus = 32'd1;
			repeat (cnt) modulus = modulus * 32'd10;
			mag = mag % modulus;
		end
		// a value that truncates to zero loses its sign
		if (mag == 32'd0)
			neg = 1'b0;
		if (neg)
			text.push_back(CH_MINUS);
		do begin
			rev_digits.push_front(CH_ZERO + 8'(mag % 32'd10));
			mag = mag / 32'd10;
		end while (mag != 32'd0);
		foreach (rev_digits[i])
			text.push_back(rev_digits[i]);
		// pad with spaces up to the field width
		width = is_signed ? int'(cnt) + 1 : int'(cnt);
		total = (text.size() > width) ? text.size() : width;
		for (int k = 0; k < total; k++) begin
			ch.code = (k < text.size()) ? text[k] : CH_SPACE;
			ch.last = (k == total - 1);
			char_expect.push_back(ch);
		end
	endfunction

	function automatic void add_number(bit is_signed, logic [31:0] value, logic [3:0] digits);
		number_req_t r;
		r.is_signed = is_signed;
		r.value     = value;
		r.digits    = digits;
		pending_numbers.push_back(r);
		numbers_total++;
	endfunction

	// Pick a value that mixes full-range, small and boundary numbers
	function automatic logic [31:0] random_value();
		logic [31:0] p;
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 9);
			1: return $urandom_range(0, 99999);
			2: return 32'h8000_0000 + $urandom_range(0, 15);
			3: return 32'h7FFF_FFFF - $urandom_range(0, 15);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			5: begin
				p = 32'd1;
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				p = p + $urandom_range(0, 2) - 1;
				return $urandom_range(0, 1) ? p : (32'd0 - p);
			end
			default: return $urandom;
		endcase
	endfunction

	// Run the cycle count and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stretch with both sides always ready
	assign calm = (cycles >= 6000) && (cycles < 14000);

	// Present requests; hold each until it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			req_fire = s_tvalid && s_tready;
			if (req_fire) begin
				predict_text(presented.is_signed, presented.value, presented.digits);
				numbers_taken++;
			end
			if (s_tvalid && !req_fire) begin
				// hold the current request
			end else if (pending_numbers.size() != 0 &&
					(calm || $urandom_range(0, 99) >= 17)) begin
				presented = pending_numbers.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {4'b0000, presented.digits, presented.value};
				s_tuser  <= presented.is_signed;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Check each character against the oldest prediction and stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (char_expect.size() == 0) begin
					errors++;
					if (errors < 40)
						$display("%0t: unexpected char code %h last %b", $time, m_tdata, m_tlast);
				end else begin
					want = char_expect.pop_front();
					if (m_tdata !== want.code || m_tlast !== want.last) begin
						errors++;
						if (errors < 40)
							$display("%0t: expected code %h last %b, got code %h last %b",
								$time, want.code, want.last, m_tdata, m_tlast);
					end
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 17);
		end
	end

	initial begin
		// directed: extremes, zero widths, wide counts, truncation
		add_number(1'b0, 32'd0,          4'd0);
		add_number(1'b1, 32'd0,          4'd0);
		add_number(1'b1, 32'd5,          4'd0);
		add_number(1'b0, 32'hFFFF_FFFF,  4'd10);
		add_number(1'b0, 32'hFFFF_FFFF,  4'd9);
		add_number(1'b0, 32'hFFFF_FFFF,  4'd15);
		add_number(1'b1, 32'h8000_0000,  4'd10);
		add_number(1'b1, 32'h8000_0000,  4'd11);
		add_number(1'b1, 32'h8000_0000,  4'd9);
		add_number(1'b1, 32'h7FFF_FFFF,  4'd10);
		add_number(1'b1, 32'h7FFF_FFFF,  4'd12);
		add_number(1'b1, 32'hFFFF_FFFF,  4'd5);
		add_number(1'b1, 32'hFFFF_FFFF,  4'd1);
		add_number(1'b1, -32'sd1000,     4'd3);
		add_number(1'b1, -32'sd123456,   4'd3);
		add_number(1'b0, 32'd123456789,  4'd9);
		add_number(1'b0, 32'd123456789,  4'd1);
		add_number(1'b0, 32'd7,          4'd13);
		add_number(1'b1, 32'd1000000000, 4'd14);
		add_number(1'b0, 32'h8000_0000,  4'd2);
		add_number(1'b1, 32'd42,         4'd0);
		add_number(1'b0, 32'd1,          4'd1);
		// random requests
		repeat (390)
			add_number($urandom_range(0, 1), random_value(), $urandom_range(0, 15));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (!(numbers_taken == numbers_total && char_expect.size() == 0))
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
